>>> hw/rtl/cap_pkg.sv
// shared types, constants and helpers for the cascaded attitude pid and motor mixer
// no dependencies
`default_nettype none
package cap_pkg;

	localparam int GainFracBits = 16;
	localparam int SampleBits   = 16;

	localparam logic [16:0] AngleErrLim = 17'd640;
	localparam logic [16:0] RateErrLim  = 17'd3200;
	localparam logic [16:0] YawErrLim   = 17'd1440;
	localparam logic [11:0] ThrMin      = 12'd1100;
	localparam logic [11:0] WinLo       = 12'd900;
	localparam logic [11:0] WinMid      = 12'd1100;
	localparam logic [11:0] WinHiLo     = 12'd1900;
	localparam logic [11:0] WinHi       = 12'd2100;
	localparam logic signed [35:0] MotorMax = 36'sd2000;
	localparam logic signed [35:0] MotorMin = 36'sd1000;
	localparam logic [16:0] FrontScale  = 17'd69468;

	localparam logic [23:0] RstOuterKp   = 24'd275251;
	localparam logic [23:0] RstOuterKi   = 24'd655;
	localparam logic [23:0] RstOuterKd   = 24'd0;
	localparam logic [15:0] RstOuterImax = 16'd160;
	localparam logic [23:0] RstInnerKp   = 24'd222822;
	localparam logic [23:0] RstInnerKi   = 24'd655;
	localparam logic [23:0] RstInnerKd   = 24'd655360;
	localparam logic [15:0] RstInnerImax = 16'd560;

	typedef enum logic [1:0] {
		OP_CTRL   = 2'd0,
		OP_ARM    = 2'd1,
		OP_DISARM = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_OUTER_KP   = 3'd0,
		REG_OUTER_KI   = 3'd1,
		REG_OUTER_KD   = 3'd2,
		REG_OUTER_IMAX = 3'd3,
		REG_INNER_KP   = 3'd4,
		REG_INNER_KI   = 3'd5,
		REG_INNER_KD   = 3'd6,
		REG_INNER_IMAX = 3'd7
	} reg_idx_t;

	// datapath steps of one control item, in issue order
	typedef enum logic [4:0] {
		U_PREP = 5'd0,
		U_OP1, U_OP2, U_OP3, U_OP4, U_OP5,
		U_OR1, U_OR2, U_OR3, U_OR4, U_OR5,
		U_IP1, U_IP2, U_IP3, U_IP4, U_IP5,
		U_IR1, U_IR2, U_IR3, U_IR4, U_IR5,
		U_IY1, U_IY2, U_IY3, U_IY4, U_IY5,
		U_B1, U_B2, U_M1, U_M2, U_M3,
		U_REQ
	} uop_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_target;
		logic signed [15:0] pitch_target;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic [11:0]        throttle;
		logic [11:0]        yaw_stick;
	} in_t;

	typedef struct packed {
		logic [10:0] motor_front;
		logic [10:0] motor_right;
		logic [10:0] motor_back;
		logic [10:0] motor_left;
		logic        motors_running;
		logic        request_accepted;
		logic        armed_now;
	} out_t;

	typedef struct packed {
		logic [23:0] outer_kp;
		logic [23:0] outer_ki;
		logic [23:0] outer_kd;
		logic [15:0] outer_imax;
		logic [23:0] inner_kp;
		logic [23:0] inner_ki;
		logic [23:0] inner_kd;
		logic [15:0] inner_imax;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic run;
		logic wr_out;
		uop_t step;
	} cmd_t;

	function automatic logic signed [47:0] sat(input logic signed [47:0] v,
		input logic [16:0] lim);
		logic signed [47:0] l;
		l = $signed({31'd0, lim});
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cap_ctrl.sv
// sequencer for the attitude controller: accepts beats and steps the datapath
// depends on cap_pkg
`default_nettype none
module cap_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          is_ctrl,
	input  wire logic          can_write,
	output logic               in_stall,
	output cap_pkg::cmd_t      cmd
);
	import cap_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q;
	uop_t   step_q;
	logic   last_step;

	assign in_stall  = (state_q != S_IDLE);
	assign last_step = (step_q == U_M3) || (step_q == U_REQ);

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.run    = (state_q == S_RUN);
		cmd.wr_out = (state_q == S_RUN) && last_step && can_write;
		cmd.step   = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= U_PREP;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						step_q  <= is_ctrl ? U_PREP : U_REQ;
					end
				end
				S_RUN: begin
					if (last_step) begin
						// hold on the final step until the output register frees up
						if (can_write) state_q <= S_IDLE;
					end else begin
						step_q <= uop_t'(step_q + 5'd1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
	a_wr_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_out |-> (step_q == U_M3 || step_q == U_REQ)) else $error("early result write");
	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_RUN) else $error("load did not start work");

endmodule
`default_nettype wire

>>> hw/rtl/cap_dp.sv
// datapath: shared multiplier, accumulator, loop state, mixer and result register
// depends on cap_pkg
`default_nettype none
module cap_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cap_pkg::cmd_t cmd,
	input  wire cap_pkg::cfg_t cfg,
	input  wire cap_pkg::in_t  in_data,
	input  wire logic          out_stall,
	output logic               can_write,
	output logic               out_valid,
	output cap_pkg::out_t      out_data
);
	import cap_pkg::*;

	in_t in_q;
	logic armed_q;
	logic signed [16:0] osum_p_q, osum_r_q, isum_p_q, isum_r_q, isum_y_q;
	logic signed [15:0] last_pa_q, last_ra_q, last_rx_q, last_ry_q, last_rz_q;
	logic signed [10:0] e_p_q, e_r_q;
	logic signed [16:0] da_p_q, da_r_q, dr_x_q, dr_y_q, dr_z_q;
	logic signed [12:0] u_p_q, u_r_q, u_y_q;
	logic signed [31:0] q_p_q, q_r_q, q_y_q;
	logic [16:0] b1_q;
	logic signed [32:0] t1_q, t2_q;
	logic signed [35:0] v0_q, v1_q, v2_q, v3_q;
	logic signed [42:0] pr_q;
	logic signed [44:0] acc_q;
	logic out_vq;
	out_t out_q;

	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [42:0] mul_p;
	logic clr, run_motors;
	logic signed [47:0] acc_sh, e_p_n, e_r_n;
	logic [11:0] thr, yaw;
	logic arm_win, disarm_win;
	out_t out_n;
	logic armed_n;

	assign thr    = in_q.throttle;
	assign yaw    = in_q.yaw_stick;
	assign clr    = (thr <= ThrMin);
	assign acc_sh = 48'(acc_q >>> GainFracBits);
	assign mul_p  = mul_a * mul_b;
	assign run_motors = armed_q && (thr >= ThrMin);
	assign arm_win    = (thr > WinLo) && (thr < WinMid) && (yaw > WinHiLo) && (yaw < WinHi);
	assign disarm_win = (thr > WinLo) && (thr < WinMid) && (yaw > WinLo) && (yaw < WinMid);

	assign e_p_n = sat(48'(in_q.pitch_angle) - 48'(in_q.pitch_target), AngleErrLim);
	assign e_r_n = sat(48'(in_q.roll_angle) - 48'(in_q.roll_target), AngleErrLim);

	assign can_write = !out_vq || !out_stall;
	assign out_valid = out_vq;
	assign out_data  = out_q;

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.step)
			U_OP1: begin mul_a = $signed({1'b0, cfg.outer_kp}); mul_b = 18'(e_p_q); end
			U_OP2: begin mul_a = $signed({1'b0, cfg.outer_ki}); mul_b = 18'(osum_p_q); end
			U_OP3: begin mul_a = $signed({1'b0, cfg.outer_kd}); mul_b = 18'(da_p_q); end
			U_OR1: begin mul_a = $signed({1'b0, cfg.outer_kp}); mul_b = 18'(e_r_q); end
			U_OR2: begin mul_a = $signed({1'b0, cfg.outer_ki}); mul_b = 18'(osum_r_q); end
			U_OR3: begin mul_a = $signed({1'b0, cfg.outer_kd}); mul_b = 18'(da_r_q); end
			U_IP1: begin mul_a = $signed({1'b0, cfg.inner_ki}); mul_b = 18'(u_p_q); end
			U_IP2: begin mul_a = $signed({1'b0, cfg.inner_kp}); mul_b = 18'(u_p_q); end
			U_IP3: begin mul_a = $signed({1'b0, cfg.inner_kd}); mul_b = 18'(dr_y_q); end
			U_IR1: begin mul_a = $signed({1'b0, cfg.inner_ki}); mul_b = 18'(u_r_q); end
			U_IR2: begin mul_a = $signed({1'b0, cfg.inner_kp}); mul_b = 18'(u_r_q); end
			U_IR3: begin mul_a = $signed({1'b0, cfg.inner_kd}); mul_b = 18'(dr_x_q); end
			U_IY1: begin mul_a = $signed({1'b0, cfg.inner_ki}); mul_b = 18'(u_y_q); end
			U_IY2: begin mul_a = $signed({1'b0, cfg.inner_kp}); mul_b = 18'(u_y_q); end
			U_IY3: begin mul_a = $signed({1'b0, cfg.inner_kd}); mul_b = 18'(dr_z_q); end
			U_B1:  begin mul_a = $signed({8'd0, FrontScale}); mul_b = $signed({6'd0, thr}); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_data;
		if (cmd.run) begin
			pr_q <= mul_p;
			unique case (cmd.step)
				U_PREP: begin
					e_p_q  <= 11'(e_p_n);
					e_r_q  <= 11'(e_r_n);
					da_p_q <= 17'(in_q.pitch_angle) - 17'(last_pa_q);
					da_r_q <= 17'(in_q.roll_angle) - 17'(last_ra_q);
					dr_x_q <= 17'(in_q.rate_x) - 17'(last_rx_q);
					dr_y_q <= 17'(in_q.rate_y) - 17'(last_ry_q);
					dr_z_q <= 17'(in_q.rate_z) - 17'(last_rz_q);
					u_y_q  <= 13'(sat(48'(in_q.rate_z), YawErrLim));
				end
				U_OP2, U_OR2: acc_q <= 45'(pr_q);
				U_OP3, U_OP4, U_OR3, U_OR4, U_IP4, U_IR4, U_IY4:
					acc_q <= acc_q + 45'(pr_q);
				U_OP5: u_p_q <= 13'(sat(acc_sh + 48'(in_q.rate_y), RateErrLim));
				U_OR5: u_r_q <= 13'(sat(acc_sh + 48'(in_q.rate_x), RateErrLim));
				// round half up on the integrator increment
				U_IP2, U_IR2, U_IY2:
					acc_q <= 45'(pr_q) + (45'sd1 <<< (GainFracBits - 1));
				U_IP3, U_IR3, U_IY3: acc_q <= 45'(pr_q);
				U_IP5: q_p_q <= 32'(acc_sh) + 32'(isum_p_q);
				U_IR5: q_r_q <= 32'(acc_sh) + 32'(isum_r_q);
				U_IY5: q_y_q <= 32'(acc_sh) + 32'(isum_y_q);
				U_B2:  b1_q <= 17'(pr_q >>> 12);
				U_M1: begin
					t1_q <= 33'(q_r_q) + 33'(q_p_q);
					t2_q <= 33'(q_r_q) - 33'(q_p_q);
				end
				U_M2: begin
					v0_q <= $signed({19'd0, b1_q}) - 36'(t1_q) - 36'(q_y_q);
					v1_q <= $signed({20'd0, thr, 4'd0}) + 36'(t2_q) + 36'(q_y_q);
					v2_q <= $signed({20'd0, thr, 4'd0}) + 36'(t1_q) - 36'(q_y_q);
					v3_q <= $signed({20'd0, thr, 4'd0}) - 36'(t2_q) + 36'(q_y_q);
				end
				default: ;
			endcase
		end
	end

	function automatic logic [10:0] motor(input logic signed [35:0] v);
		logic signed [35:0] m;
		m = v >>> 4;
		if (m > MotorMax) m = MotorMax;
		if (m < MotorMin) m = MotorMin;
		return 11'(m);
	endfunction

	// next result beat and armed flag
	always_comb begin
		out_n   = '0;
		armed_n = armed_q;
		if (cmd.step == U_M3) begin
			out_n.armed_now = armed_q;
			if (run_motors) begin
				out_n.motor_front    = motor(v0_q);
				out_n.motor_right    = motor(v1_q);
				out_n.motor_back     = motor(v2_q);
				out_n.motor_left     = motor(v3_q);
				out_n.motors_running = 1'b1;
			end
		end else begin
			unique case (op_t'(in_q.op))
				OP_ARM: begin
					if (arm_win) armed_n = 1'b1;
					out_n.request_accepted = arm_win;
				end
				OP_DISARM: begin
					if (disarm_win) armed_n = 1'b0;
					out_n.request_accepted = disarm_win;
				end
				default: ;
			endcase
			out_n.armed_now = armed_n;
		end
	end

	// loop state, armed flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			osum_p_q  <= '0;
			osum_r_q  <= '0;
			isum_p_q  <= '0;
			isum_r_q  <= '0;
			isum_y_q  <= '0;
			last_pa_q <= '0;
			last_ra_q <= '0;
			last_rx_q <= '0;
			last_ry_q <= '0;
			last_rz_q <= '0;
			out_vq    <= 1'b0;
			out_q     <= '0;
		end else begin
			out_vq <= cmd.wr_out || (out_vq && out_stall);
			if (cmd.run) begin
				unique case (cmd.step)
					U_PREP: begin
						osum_p_q  <= clr ? '0 : 17'(sat(48'(osum_p_q) + e_p_n,
							{1'b0, cfg.outer_imax}));
						osum_r_q  <= clr ? '0 : 17'(sat(48'(osum_r_q) + e_r_n,
							{1'b0, cfg.outer_imax}));
						last_pa_q <= in_q.pitch_angle;
						last_ra_q <= in_q.roll_angle;
						last_rx_q <= in_q.rate_x;
						last_ry_q <= in_q.rate_y;
						last_rz_q <= in_q.rate_z;
					end
					U_IP3: isum_p_q <= clr ? '0 : 17'(sat(48'(isum_p_q) + acc_sh,
						{1'b0, cfg.inner_imax}));
					U_IR3: isum_r_q <= clr ? '0 : 17'(sat(48'(isum_r_q) + acc_sh,
						{1'b0, cfg.inner_imax}));
					U_IY3: isum_y_q <= clr ? '0 : 17'(sat(48'(isum_y_q) + acc_sh,
						{1'b0, cfg.inner_imax}));
					default: ;
				endcase
			end
			if (cmd.wr_out) begin
				out_q   <= out_n;
				armed_q <= armed_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cascaded_attitude_pid_motor_mix.sv
// Cascaded attitude controller with X-frame motor mixing. A control beat (op 0) holds
// off the next beat while it runs: the beat is taken, then 31 sequencer steps run
// through a single shared 25x18 multiplier, which does every gain product of the outer
// angle loops, the inner rate loops and the front motor scale. Arm, disarm and unused-op
// beats go straight to the final request step. The result sits in an output register, so
// the next beat is taken while a finished result waits on out_stall; a final step that
// finds the output register still full holds until it is taken. Gains are Q8.16, angles
// and rates 1/16 units. Configuration over APB is to be written only while the block is
// idle; the block itself does not enforce this.
// depends on cap_pkg, cap_ctrl, cap_dp
`default_nettype none
module cascaded_attitude_pid_motor_mix (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire cap_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_stall,
	output cap_pkg::out_t     out_data,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import cap_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	logic can_write;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_kp   <= RstOuterKp;
			cfg_q.outer_ki   <= RstOuterKi;
			cfg_q.outer_kd   <= RstOuterKd;
			cfg_q.outer_imax <= RstOuterImax;
			cfg_q.inner_kp   <= RstInnerKp;
			cfg_q.inner_ki   <= RstInnerKi;
			cfg_q.inner_kd   <= RstInnerKd;
			cfg_q.inner_imax <= RstInnerImax;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_OUTER_KP:   cfg_q.outer_kp   <= pwdata[23:0];
				REG_OUTER_KI:   cfg_q.outer_ki   <= pwdata[23:0];
				REG_OUTER_KD:   cfg_q.outer_kd   <= pwdata[23:0];
				REG_OUTER_IMAX: cfg_q.outer_imax <= pwdata[15:0];
				REG_INNER_KP:   cfg_q.inner_kp   <= pwdata[23:0];
				REG_INNER_KI:   cfg_q.inner_ki   <= pwdata[23:0];
				REG_INNER_KD:   cfg_q.inner_kd   <= pwdata[23:0];
				REG_INNER_IMAX: cfg_q.inner_imax <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_OUTER_KP:   prdata = {8'd0, cfg_q.outer_kp};
			REG_OUTER_KI:   prdata = {8'd0, cfg_q.outer_ki};
			REG_OUTER_KD:   prdata = {8'd0, cfg_q.outer_kd};
			REG_OUTER_IMAX: prdata = {16'd0, cfg_q.outer_imax};
			REG_INNER_KP:   prdata = {8'd0, cfg_q.inner_kp};
			REG_INNER_KI:   prdata = {8'd0, cfg_q.inner_ki};
			REG_INNER_KD:   prdata = {8'd0, cfg_q.inner_kd};
			REG_INNER_IMAX: prdata = {16'd0, cfg_q.inner_imax};
			default:        prdata = '0;
		endcase
	end

	cap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.is_ctrl   (in_data.op == OP_CTRL),
		.can_write (can_write),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	cap_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.in_data   (in_data),
		.out_stall (out_stall),
		.can_write (can_write),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

>>> verif/cascaded_attitude_pid_motor_mix_test.sv
// self-checking bench for the cascaded attitude pid and motor mixer: directed and random
// control, arm and disarm beats, apb gain changes between phases, random sender/receiver idling
// depends on cap_pkg and cascaded_attitude_pid_motor_mix
`default_nettype none
module cascaded_attitude_pid_motor_mix_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cap_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	cascaded_attitude_pid_motor_mix dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// predictor state
	longint gain [8];
	bit armed;
	longint osum_r, osum_p, olast_r, olast_p;
	longint isum [3];
	longint ilast [3];

	in_t pending_beats [$];
	out_t expected_motors [$];
	int errors = 0;
	int n_ctrl = 0, n_req = 0, n_running = 0, n_results = 0, n_beats = 0;
	bit stim_done = 1'b0;
	bit in_taken = 1'b0;

	function automatic longint clampl(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// arithmetic shift is a floor divide for 64-bit signed values
	function automatic longint fdiv(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint angle_pid(longint ang, longint tgt, ref longint s,
		ref longint last, input bit clr);
		longint e;
		longint acc;
		e = clampl(ang - tgt, 640);
		s = clampl(s + e, gain[REG_OUTER_IMAX]);
		if (clr) s = 0;
		acc = gain[REG_OUTER_KP] * e + gain[REG_OUTER_KI] * s + gain[REG_OUTER_KD] * (ang - last);
		last = ang;
		return fdiv(acc, GainFracBits);
	endfunction

	function automatic longint rate_pid(longint u, longint rate, int ax, bit clr);
		longint inc;
		longint acc;
		inc = fdiv(gain[REG_INNER_KI] * u + (64'sd1 << (GainFracBits - 1)), GainFracBits);
		isum[ax] = clampl(isum[ax] + inc, gain[REG_INNER_IMAX]);
		if (clr) isum[ax] = 0;
		acc = gain[REG_INNER_KP] * u + gain[REG_INNER_KD] * (rate - ilast[ax]);
		ilast[ax] = rate;
		return fdiv(acc, GainFracBits) + isum[ax];
	endfunction

	function automatic logic [10:0] motor_cmd(longint v16);
		longint m;
		m = fdiv(v16, 4);
		if (m > 2000) m = 2000;
		if (m < 1000) m = 1000;
		return 11'(m);
	endfunction

	function automatic out_t mix_attitude(in_t b);
		out_t r;
		bit clr;
		bit win;
		longint po, ro, pu, ru, yu, p, rr, y, b1, b0;
		r = '0;
		win = b.throttle > WinLo && b.throttle < WinMid;
		case (op_t'(b.op))
			OP_CTRL: begin
				clr = b.throttle <= ThrMin;
				po = angle_pid(b.pitch_angle, b.pitch_target, osum_p, olast_p, clr);
				ro = angle_pid(b.roll_angle, b.roll_target, osum_r, olast_r, clr);
				pu = clampl(po + b.rate_y, 3200);
				ru = clampl(ro + b.rate_x, 3200);
				yu = clampl(longint'(b.rate_z), 1440);
				p = rate_pid(pu, b.rate_y, 1, clr);
				rr = rate_pid(ru, b.rate_x, 0, clr);
				y = rate_pid(yu, b.rate_z, 2, clr);
				if (armed && b.throttle >= ThrMin) begin
					b0 = longint'(b.throttle) * 16;
					b1 = (b0 * 69468) >>> 16;
					r.motor_front = motor_cmd(b1 - rr - p - y);
					r.motor_right = motor_cmd(b0 + rr - p + y);
					r.motor_back = motor_cmd(b0 + rr + p - y);
					r.motor_left = motor_cmd(b0 - rr + p + y);
					r.motors_running = 1'b1;
				end
			end
			OP_ARM: begin
				if (win && b.yaw_stick > WinHiLo && b.yaw_stick < WinHi) begin
					armed = 1'b1;
					r.request_accepted = 1'b1;
				end
			end
			OP_DISARM: begin
				if (win && b.yaw_stick > WinLo && b.yaw_stick < WinMid) begin
					armed = 1'b0;
					r.request_accepted = 1'b1;
				end
			end
			default: ;
		endcase
		r.armed_now = armed;
		return r;
	endfunction

	// input acceptance is seen at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_motors.push_back(mix_attitude(in_data));
			n_beats++;
			in_taken = 1'b1;
		end else begin
			in_taken = 1'b0;
		end
	end

	// driver: bursts and gaps on the sender side
	int gap_left = 0;
	int burst_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_data <= pending_beats.pop_front();
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
			// receiver stall pattern: phases of no stall, light and heavy stall
			case ((n_results / 150) % 3)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_motors.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", out_data);
			end else begin
				e = expected_motors.pop_front();
				if (e.motors_running) n_running++;
				if (out_data !== e) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: front %0d/%0d right %0d/%0d back %0d/%0d ",
							"left %0d/%0d run %b/%b acc %b/%b armed %b/%b (exp/act)"},
							e.motor_front, out_data.motor_front, e.motor_right,
							out_data.motor_right, e.motor_back, out_data.motor_back,
							e.motor_left, out_data.motor_left, e.motors_running,
							out_data.motors_running, e.request_accepted,
							out_data.request_accepted, e.armed_now, out_data.armed_now);
				end
			end
		end
	end

	task automatic apb_write(reg_idx_t idx, longint val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		gain[idx] = val;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || in_valid || expected_motors.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic in_t rand_beat(op_t op, bit wide);
		in_t b;
		b = in_t'(138'({$urandom, $urandom, $urandom, $urandom, $urandom}));
		b.op = op;
		if (!wide) begin
			b.roll_angle = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
			b.pitch_angle = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
			b.roll_target = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
			b.pitch_target = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
			b.rate_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			b.rate_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			b.rate_z = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
			b.throttle = 12'($urandom_range(1050, 2000));
		end
		if (op != OP_CTRL) begin
			b.throttle = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
				12'($urandom_range(880, 1120));
			b.yaw_stick = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
				(($urandom_range(0, 1) != 0) ? 12'($urandom_range(1880, 2120)) :
				12'($urandom_range(880, 1120)));
		end
		return b;
	endfunction

	function automatic in_t stick_beat(op_t op, int thr, int yaw);
		in_t b;
		b = '0;
		b.op = op;
		b.throttle = 12'(thr);
		b.yaw_stick = 12'(yaw);
		return b;
	endfunction

	task automatic random_phase(int n);
		int k;
		op_t op;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0: op = OP_ARM;
				1: op = OP_DISARM;
				2: op = OP_NONE;
				default: op = OP_CTRL;
			endcase
			pending_beats.push_back(rand_beat(op, $urandom_range(0, 7) == 0));
			if ($urandom_range(0, 60) == 0)
				pending_beats.push_back(stick_beat(OP_ARM, 1000, 2000));
		end
		n_ctrl += n;
	endtask

	initial begin
		in_t b;
		gain = '{RstOuterKp, RstOuterKi, RstOuterKd, RstOuterImax,
			RstInnerKp, RstInnerKi, RstInnerKd, RstInnerImax};
		armed = 0;
		osum_r = 0; osum_p = 0; olast_r = 0; olast_p = 0;
		isum = '{0, 0, 0};
		ilast = '{0, 0, 0};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: windows, unused op, extremes, integrator clear
		pending_beats.push_back(stick_beat(OP_CTRL, 1500, 1500));
		pending_beats.push_back(stick_beat(OP_ARM, 900, 2000));
		pending_beats.push_back(stick_beat(OP_ARM, 1000, 2100));
		pending_beats.push_back(stick_beat(OP_ARM, 901, 1901));
		pending_beats.push_back(stick_beat(OP_NONE, 1000, 2000));
		b = '1; b.op = OP_CTRL; pending_beats.push_back(b);
		b = '0; b.op = OP_CTRL; b.throttle = 1100; pending_beats.push_back(b);
		b.roll_angle = 16'sh7fff; b.pitch_angle = 16'sh8000;
		b.roll_target = 16'sh8000; b.pitch_target = 16'sh7fff;
		b.rate_x = 16'sh7fff; b.rate_y = 16'sh8000; b.rate_z = 16'sh7fff;
		b.throttle = 4095; pending_beats.push_back(b);
		b.roll_angle = 16'sh8000; b.pitch_angle = 16'sh7fff;
		b.rate_x = 16'sh8000; b.rate_y = 16'sh7fff; b.rate_z = 16'sh8000;
		b.throttle = 1101; pending_beats.push_back(b);
		b.throttle = 1099; pending_beats.push_back(b);
		b.throttle = 1000; b.rate_z = 16'sd100; pending_beats.push_back(b);
		pending_beats.push_back(stick_beat(OP_DISARM, 1099, 1099));
		pending_beats.push_back(stick_beat(OP_DISARM, 1000, 900));
		b.throttle = 1500; pending_beats.push_back(b);
		pending_beats.push_back(stick_beat(OP_ARM, 1099, 2099));
		n_req += 8;
		wait_drained();

		random_phase(700);
		wait_drained();
		apb_write(REG_OUTER_KP, 0);
		apb_write(REG_OUTER_KI, 24'hffffff);
		apb_write(REG_OUTER_KD, 24'hffffff);
		apb_write(REG_OUTER_IMAX, 16'hffff);
		apb_write(REG_INNER_KP, 24'hffffff);
		apb_write(REG_INNER_KI, 24'hffffff);
		apb_write(REG_INNER_KD, 0);
		apb_write(REG_INNER_IMAX, 16'hffff);
		random_phase(400);
		wait_drained();
		apb_write(REG_OUTER_KP, $urandom_range(0, 24'h7ffff));
		apb_write(REG_OUTER_KI, 0);
		apb_write(REG_OUTER_KD, $urandom_range(0, 24'h3ffff));
		apb_write(REG_OUTER_IMAX, 0);
		apb_write(REG_INNER_KP, $urandom_range(0, 24'h7ffff));
		apb_write(REG_INNER_KI, 0);
		apb_write(REG_INNER_KD, $urandom_range(0, 24'hfffff));
		apb_write(REG_INNER_IMAX, 0);
		random_phase(400);
		wait_drained();
		apb_write(REG_OUTER_KP, RstOuterKp);
		apb_write(REG_OUTER_KI, $urandom_range(0, 24'h3fff));
		apb_write(REG_OUTER_IMAX, $urandom_range(1, 2000));
		apb_write(REG_INNER_KI, $urandom_range(0, 24'h3fff));
		apb_write(REG_INNER_IMAX, $urandom_range(1, 2000));
		apb_write(REG_INNER_KP, RstInnerKp);
		random_phase(420);
		wait_drained();

		$display("covered %0d beats (%0d directed stick beats), %0d results, %0d with motors running",
			n_beats, n_req, n_results, n_running);
		$display("gain settings: reset, upper extremes, zero integrators, mid values");
		if (errors == 0 && expected_motors.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", errors);
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
